// ----- hw/rtl/bfdd_pkg.sv -----
// Shared widths and constants for the binary fraction to decimal digit converter.
package bfdd_pkg;

  localparam int unsigned DigitW     = 4;
  localparam int unsigned PosW       = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic [DigitW-1:0] MaxDigit = DigitW'(9);

endpackage

// ----- hw/rtl/bfdd_front.sv -----
// Front stage: takes a mantissa word, splits it into integer digit and fraction.
module bfdd_front #(
  parameter int unsigned MantissaBits = 64
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic [MantissaBits-1:0]                     mantissa_i,
  output logic                                        busy_o,
  output logic                                        push_o,
  output logic [bfdd_pkg::DigitW+MantissaBits-2:0]    push_data_o,
  input  logic                                        full_i
);
  import bfdd_pkg::*;

  localparam int unsigned FracBits = MantissaBits - 1;

  logic                          valid_q, valid_d;
  logic [DigitW-1:0]             int_digit_q;
  logic [FracBits-1:0]           frac_q;
  logic                          accept;

  assign busy_o = valid_q && full_i;
  assign accept = start_i && !busy_o;
  assign push_o = valid_q && !full_i;
  assign push_data_o = {int_digit_q, frac_q};

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // integer digit is just the top bit: value lies in [0,2)
  always_ff @(posedge clk_i) begin
    if (accept) begin
      int_digit_q <= {{(DigitW-1){1'b0}}, mantissa_i[FracBits]};
      frac_q      <= mantissa_i[FracBits-1:0];
    end
  end

endmodule

// ----- hw/rtl/bfdd_queue.sv -----
// Short FIFO between the front stage and the digit generator.
module bfdd_queue #(
  parameter int unsigned Width = 67
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o
);
  import bfdd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [Width-1:0] entry_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CntW'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/bfdd_back.sv -----
// Digit generator: multiplies the fraction by ten each cycle, MantissaBits digits per word.
module bfdd_back #(
  parameter int unsigned MantissaBits = 64
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     empty_i,
  input  logic [bfdd_pkg::DigitW+MantissaBits-2:0] pop_data_i,
  output logic                                     pop_o,
  output logic                                     valid_o,
  output logic [bfdd_pkg::DigitW-1:0]              digit_o,
  output logic [bfdd_pkg::PosW-1:0]                digit_position_o,
  output logic                                     last_o
);
  import bfdd_pkg::*;

  localparam int unsigned FracBits = MantissaBits - 1;
  localparam int unsigned ProdW    = FracBits + DigitW;
  localparam logic [PosW-1:0] LastPos = PosW'(FracBits);

  logic                 active_q, active_d;
  logic                 valid_q, valid_d;
  logic                 last_q, last_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [DigitW-1:0]    digit_q, digit_d;
  logic [FracBits-1:0]  frac_q, frac_d;
  logic [ProdW-1:0]     frac_ext, prod;
  logic                 stepping;

  // 10*f = 8f + 2f; the digit is whatever crosses the binary point
  assign frac_ext = {{DigitW{1'b0}}, frac_q};
  assign prod     = (frac_ext << 3) + (frac_ext << 1);
  assign stepping = active_q && (pos_q != LastPos);
  assign pop_o    = !stepping && !empty_i;

  always_comb begin
    active_d = active_q;
    valid_d  = 1'b0;
    last_d   = 1'b0;
    pos_d    = pos_q;
    digit_d  = digit_q;
    frac_d   = frac_q;
    if (stepping) begin
      valid_d = 1'b1;
      pos_d   = pos_q + PosW'(1);
      last_d  = (pos_q + PosW'(1) == LastPos);
      digit_d = prod[ProdW-1:FracBits];
      frac_d  = prod[FracBits-1:0];
    end else if (!empty_i) begin
      active_d = 1'b1;
      valid_d  = 1'b1;
      pos_d    = '0;
      digit_d  = pop_data_i[DigitW+FracBits-1:FracBits];
      frac_d   = pop_data_i[FracBits-1:0];
    end else begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
      pos_q    <= '0;
    end else begin
      active_q <= active_d;
      valid_q  <= valid_d;
      last_q   <= last_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    frac_q  <= frac_d;
  end

  assign valid_o          = valid_q;
  assign digit_o          = digit_q;
  assign digit_position_o = pos_q;
  assign last_o           = last_q;

  a_pos_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (pos_q != '0) |-> $past(valid_q) && (pos_q == $past(pos_q) + PosW'(1)))
    else $error("digit position skipped or repeated");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> digit_q <= MaxDigit)
    else $error("digit out of decimal range");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> valid_q && (pos_q == LastPos))
    else $error("last flag off the final position");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (pos_q == '0) && $past(valid_q) |-> $past(last_q))
    else $error("new run started before previous run ended");

endmodule

// ----- hw/rtl/binary_fraction_to_decimal_digits_top.sv -----
// Top level of the binary fraction to decimal digit converter.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | start_i & !busy_o    | mantissa_i
//   result   | valid_o (one cycle)  | digit_o, digit_position_o, last_o
//
// Each word yields MANTISSA_BITS digits on consecutive cycles from the digit
// loop (one times-ten step per cycle); a new run starts only after the last
// digit of the previous one. A word passes the front register and the queue
// before it reaches the digit loop. Two words queue behind the front register
// before busy_o rises. Reset is asynchronous and clears all control state.
// The receiver cannot stall: each result is valid for exactly one cycle.
module binary_fraction_to_decimal_digits_top #(
  parameter int unsigned MANTISSA_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [MANTISSA_BITS-1:0]      mantissa_i,
  output logic                          busy_o,
  output logic                          valid_o,
  output logic [bfdd_pkg::DigitW-1:0]   digit_o,
  output logic [bfdd_pkg::PosW-1:0]     digit_position_o,
  output logic                          last_o
);
  import bfdd_pkg::*;

  localparam int unsigned EntryW = DigitW + MANTISSA_BITS - 1;

  logic              push, full, pop, empty;
  logic [EntryW-1:0] push_data, pop_data;

  bfdd_front #(
    .MantissaBits(MANTISSA_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .mantissa_i (mantissa_i),
    .busy_o     (busy_o),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  bfdd_queue #(
    .Width(EntryW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  bfdd_back #(
    .MantissaBits(MANTISSA_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .pop_data_i      (pop_data),
    .pop_o           (pop),
    .valid_o         (valid_o),
    .digit_o         (digit_o),
    .digit_position_o(digit_position_o),
    .last_o          (last_o)
  );

endmodule

// ----- test/bfdd_digit_checker.sv -----
// Checker for the binary fraction to decimal digit converter: predicts digit runs and compares.
`timescale 1ns / 1ps

module bfdd_digit_checker #(
  parameter int unsigned MANTISSA_BITS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [MANTISSA_BITS-1:0]    mantissa_i,
  input  logic                        busy_o,
  input  logic                        valid_o,
  input  logic [bfdd_pkg::DigitW-1:0] digit_o,
  input  logic [bfdd_pkg::PosW-1:0]   digit_position_o,
  input  logic                        last_o,
  output int                          errors_o,
  output int                          pending_o
);
  import bfdd_pkg::*;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic [PosW-1:0]   pos;
    logic              last;
  } digit_word_t;

  digit_word_t awaited_digits_q[$];
  int          mismatches = 0;
  int          awaited_count = 0;

  assign errors_o  = mismatches;
  assign pending_o = awaited_count;

  // Integer bit first, then one times-ten step per fractional digit.
  task automatic expand_mantissa(input logic [MANTISSA_BITS-1:0] m);
    logic [MANTISSA_BITS+2:0] prod;
    logic [MANTISSA_BITS-2:0] frac;
    digit_word_t              w;
    w.digit = DigitW'(m[MANTISSA_BITS-1]);
    w.pos   = '0;
    w.last  = 1'b0;
    awaited_digits_q.push_back(w);
    frac = m[MANTISSA_BITS-2:0];
    for (int k = 1; k < MANTISSA_BITS; k++) begin
      prod    = (MANTISSA_BITS+3)'(frac);
      prod    = prod * 10;
      w.digit = prod[MANTISSA_BITS+2:MANTISSA_BITS-1];
      w.pos   = PosW'(k);
      w.last  = (k == MANTISSA_BITS - 1);
      frac    = prod[MANTISSA_BITS-2:0];
      awaited_digits_q.push_back(w);
    end
  endtask

  always @(posedge clk_i) begin
    digit_word_t exp_w;
    if (rst_ni) begin
      if (valid_o === 1'b1) begin
        if (awaited_digits_q.size() == 0) begin
          $error("unexpected digit word: digit %0d position %0d last %0b",
                 digit_o, digit_position_o, last_o);
          mismatches++;
        end else begin
          exp_w = awaited_digits_q.pop_front();
          if (digit_o !== exp_w.digit) begin
            $error("digit: expected %0d, actual %0d", exp_w.digit, digit_o);
            mismatches++;
          end
          if (digit_position_o !== exp_w.pos) begin
            $error("digit_position: expected %0d, actual %0d", exp_w.pos, digit_position_o);
            mismatches++;
          end
          if (last_o !== exp_w.last) begin
            $error("last: expected %0b, actual %0b", exp_w.last, last_o);
            mismatches++;
          end
        end
      end
      if (start_i && busy_o === 1'b0) expand_mantissa(mantissa_i);
      awaited_count <= awaited_digits_q.size();
    end
  end

endmodule

// ----- test/binary_fraction_to_decimal_digits_top_test.sv -----
// Testbench top for the binary fraction to decimal digit converter: stimulus and verdict.
`timescale 1ns / 1ps

module binary_fraction_to_decimal_digits_top_test;
  import bfdd_pkg::*;

  localparam int unsigned MANTISSA_BITS = 64;
  localparam int          StallLimit    = 2000;
  localparam int          RandomWords   = 85;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic [MANTISSA_BITS-1:0] mantissa_i;
  logic                     busy_o;
  logic                     valid_o;
  logic [DigitW-1:0]        digit_o;
  logic [PosW-1:0]          digit_position_o;
  logic                     last_o;
  int                       errors;
  int                       pending;

  binary_fraction_to_decimal_digits_top #(
    .MANTISSA_BITS(MANTISSA_BITS)
  ) DUT (
    .clk_i, .rst_ni, .start_i, .mantissa_i, .busy_o,
    .valid_o, .digit_o, .digit_position_o, .last_o
  );

  bfdd_digit_checker #(
    .MANTISSA_BITS(MANTISSA_BITS)
  ) digit_check (
    .clk_i, .rst_ni, .start_i, .mantissa_i, .busy_o,
    .valid_o, .digit_o, .digit_position_o, .last_o,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // start_i stays high from one word to the next unless the sender idles
  task automatic send_word(input logic [MANTISSA_BITS-1:0] m);
    start_i    <= 1'b1;
    mantissa_i <= m;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Random idle cycles; now and then hold off until the backlog drops to a
  // random depth so new words land on every phase of a run.
  task automatic idle_before_word(input int idle_pct);
    int backlog_cap;
    backlog_cap = ($urandom_range(7) == 0) ? $urandom_range(127) : 1 << 20;
    while ($urandom_range(99) < idle_pct || pending > backlog_cap) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic logic [MANTISSA_BITS-1:0] random_mantissa();
    logic [MANTISSA_BITS-1:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(9))
      0: m = MANTISSA_BITS'(1) << $urandom_range(MANTISSA_BITS - 1);
      1: m = ~(MANTISSA_BITS'(1) << $urandom_range(MANTISSA_BITS - 1));
      2: m = MANTISSA_BITS'($urandom_range(255));
      3: m = m & ~(MANTISSA_BITS'(0) - 1 >> $urandom_range(MANTISSA_BITS - 1));
      default: ;
    endcase
    return m;
  endfunction

  logic [MANTISSA_BITS-1:0] corner_words [] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'h0000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001,
    64'h4000_0000_0000_0000, 64'h2000_0000_0000_0000, 64'hC000_0000_0000_0000,
    64'h6666_6666_6666_6666, 64'hCCCC_CCCC_CCCC_CCCC, 64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
    64'h1999_9999_9999_999A, 64'h0CCC_CCCC_CCCC_CCCD, 64'h7333_3333_3333_3333,
    64'hFE00_0000_0000_0000, 64'h0000_0000_0000_0002
  };

  int idle_pct_by_phase [3] = '{20, 79, 0};

  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    mantissa_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (corner_words[i]) begin
      idle_before_word(idle_pct_by_phase[0]);
      send_word(corner_words[i]);
    end

    // hold the sender until every digit of the corner words is out
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);

    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < RandomWords; n++) begin
        idle_before_word(idle_pct_by_phase[phase]);
        send_word(random_mantissa());
      end
    end

    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // counts cycles with neither an accepted word nor a digit word
  initial begin
    int stall;
    stall = 0;
    while (stall < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (start_i && busy_o === 1'b0) || valid_o === 1'b1) begin
        stall = 0;
      end else begin
        stall++;
      end
    end
    $error("no progress for %0d cycles", StallLimit);
    $display("status: fail");
    $finish;
  end

endmodule
